@@ design/delimited_frame_extractor_core_defines.svh @@
// Assertion macros shared by the deframer RTL.
// Both expect clk and rst_n in scope at the place of use.
`ifndef DELIMITED_FRAME_EXTRACTOR_CORE_DEFINES_SVH
`define DELIMITED_FRAME_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define DFE_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define DFE_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ design/dfe_pkg.sv @@
package dfe_pkg;

  // Frame store depth and pattern limits
  localparam int FRAME_MAX = 64;
  localparam int PAT_MAX   = 4;
  localparam int PAT_CAP   = (PAT_MAX < 4) ? PAT_MAX : 4;

  localparam int CNT_W = $clog2(FRAME_MAX + 1);
  localparam int IDX_W = $clog2(FRAME_MAX);
  localparam int REC_W = 8 * PAT_CAP;

  // Byte counter after a delimiter, saturating
  localparam int         BSS_W   = 4;
  localparam logic [3:0] BSS_SAT = 4'd8;

  // Register file
  localparam int         ADDR_W = 5;
  localparam int         DATA_W = 32;
  localparam logic [2:0] REG_FIXED_MODE    = 3'd0;
  localparam logic [2:0] REG_START_PATTERN = 3'd1;
  localparam logic [2:0] REG_START_LENGTH  = 3'd2;
  localparam logic [2:0] REG_END_PATTERN   = 3'd3;
  localparam logic [2:0] REG_END_LENGTH    = 3'd4;
  localparam logic [2:0] REG_FRAME_LIMIT   = 3'd5;

  // Clamped configuration seen by the datapath
  typedef struct packed {
    logic             fixed;
    logic [31:0]      start_pat;
    logic [31:0]      end_pat;
    logic [2:0]       sl;
    logic [2:0]       el;
    logic [CNT_W-1:0] lim;
    logic             restart;
  } cfg_t;

  // Broadcast control for the cell row
  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [IDX_W-1:0] wr_ptr;
    logic [7:0]       wr_byte;
    logic             hdr_load;
    logic [2:0]       hdr_cnt;
    logic [31:0]      hdr_pat;
  } cell_ctl_t;

endpackage

@@ design/dfe_if.sv @@
// Received byte channel
interface dfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Frame byte channel
interface dfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;
  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

@@ design/dfe_cfg_regs.sv @@
module dfe_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dfe_pkg::ADDR_W-1:0]  paddr,
  input  logic [dfe_pkg::DATA_W-1:0]  pwdata,
  output logic [dfe_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output dfe_pkg::cfg_t               cfg
);

  logic        fixed_r;
  logic [31:0] start_pat_r;
  logic [2:0]  start_len_r;
  logic [31:0] end_pat_r;
  logic [2:0]  end_len_r;
  logic [6:0]  limit_r;
  logic        wr;
  logic        wr_known;
  logic [2:0]  reg_sel;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;
  assign reg_sel  = paddr[dfe_pkg::ADDR_W-1:2];
  assign wr_known = wr && (reg_sel <= dfe_pkg::REG_FRAME_LIMIT);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_r     <= 1'b0;
      start_pat_r <= '0;
      start_len_r <= 3'd1;
      end_pat_r   <= '0;
      end_len_r   <= 3'd1;
      limit_r     <= 7'd64;
    end else begin
      if (wr) begin
        case (reg_sel)
          dfe_pkg::REG_FIXED_MODE:    fixed_r     <= pwdata[0];
          dfe_pkg::REG_START_PATTERN: start_pat_r <= pwdata[31:0];
          dfe_pkg::REG_START_LENGTH:  start_len_r <= pwdata[2:0];
          dfe_pkg::REG_END_PATTERN:   end_pat_r   <= pwdata[31:0];
          dfe_pkg::REG_END_LENGTH:    end_len_r   <= pwdata[2:0];
          dfe_pkg::REG_FRAME_LIMIT:   limit_r     <= pwdata[6:0];
          default:                    ;
        endcase
      end
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      dfe_pkg::REG_FIXED_MODE:    prdata = dfe_pkg::DATA_W'(fixed_r);
      dfe_pkg::REG_START_PATTERN: prdata = dfe_pkg::DATA_W'(start_pat_r);
      dfe_pkg::REG_START_LENGTH:  prdata = dfe_pkg::DATA_W'(start_len_r);
      dfe_pkg::REG_END_PATTERN:   prdata = dfe_pkg::DATA_W'(end_pat_r);
      dfe_pkg::REG_END_LENGTH:    prdata = dfe_pkg::DATA_W'(end_len_r);
      dfe_pkg::REG_FRAME_LIMIT:   prdata = dfe_pkg::DATA_W'(limit_r);
      default:                    prdata = '0;
    endcase
  end

  // Clamp lengths and limit into their working ranges
  always_comb begin
    cfg.fixed     = fixed_r;
    cfg.start_pat = start_pat_r;
    cfg.end_pat   = end_pat_r;
    // Restart lands on the same edge as the write to a known register
    cfg.restart   = wr_known;
    cfg.sl = (start_len_r > 3'(dfe_pkg::PAT_CAP)) ? 3'(dfe_pkg::PAT_CAP) : start_len_r;
    if (end_len_r == 3'd0) cfg.el = 3'd1;
    else if (end_len_r > 3'(dfe_pkg::PAT_CAP)) cfg.el = 3'(dfe_pkg::PAT_CAP);
    else cfg.el = end_len_r;
    if (limit_r == 7'd0) cfg.lim = dfe_pkg::CNT_W'(1);
    else if (8'(limit_r) > 8'(dfe_pkg::FRAME_MAX)) cfg.lim = dfe_pkg::CNT_W'(dfe_pkg::FRAME_MAX);
    else cfg.lim = dfe_pkg::CNT_W'(limit_r);
  end

endmodule

@@ design/dfe_cell.sv @@
module dfe_cell (
  input  logic                       clk,
  input  logic [dfe_pkg::IDX_W-1:0]  cell_idx,
  input  dfe_pkg::cell_ctl_t         ctl,
  input  logic [7:0]                 nbr_byte,
  output logic [7:0]                 cell_byte
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;
  logic       hdr_hit;
  logic [1:0] hdr_sel;
  logic [7:0] hdr_byte;

  // Header bytes land in the first cells in one step
  assign hdr_hit  = ctl.hdr_load &&
                    (dfe_pkg::CNT_W'(cell_idx) < dfe_pkg::CNT_W'(ctl.hdr_cnt));
  assign hdr_sel  = 2'(cell_idx);
  assign hdr_byte = 8'(ctl.hdr_pat >> {hdr_sel, 3'b000});

  // Header load, then direct write, then shift from the neighbor
  always_comb begin
    data_nxt = data_r;
    if (hdr_hit) data_nxt = hdr_byte;
    else if (ctl.wr_en && (cell_idx == ctl.wr_ptr)) data_nxt = ctl.wr_byte;
    else if (ctl.shift) data_nxt = nbr_byte;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign cell_byte = data_r;

endmodule

@@ design/delimited_frame_extractor_core.sv @@
// Delimited frame extractor.
// in_ch carries received bytes, one per transfer; out_ch carries frame bytes
// in order with frame_last on the final byte. Configuration is an APB-style
// port (pready always high); a write to a defined register restarts framing
// on its access edge.
// Bytes sit in a row of 64 byte cells. When a byte closes a frame, the first
// frame byte is offered on the next cycle and the row shifts one cell toward
// cell 0 per out transfer.
// Sustained rate: one byte per cycle while no frame drains; the input is
// held off while each emitted frame drains, output stalls included.
// in_ch.ready is low exactly while a frame is draining.
// If the receiver stalls, the current frame byte and frame_last hold.
// Reset (rst_n low, synchronous) returns to hunting for a start pattern with
// delimiter mode, start/end length 1, patterns zero and a 64-byte limit.
// Cell contents need no clearing after reset.
`include "delimited_frame_extractor_core_defines.svh"

module delimited_frame_extractor_core (
  input  logic                        clk,
  input  logic                        rst_n,
  dfe_in_if.sink                      in_ch,
  dfe_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dfe_pkg::ADDR_W-1:0]  paddr,
  input  logic [dfe_pkg::DATA_W-1:0]  pwdata,
  output logic [dfe_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int CW = dfe_pkg::CNT_W;
  localparam int IW = dfe_pkg::IDX_W;
  localparam int RW = dfe_pkg::REC_W;
  localparam int BW = dfe_pkg::BSS_W;

  dfe_pkg::cfg_t      cfg;
  dfe_pkg::cell_ctl_t cell_ctl;
  logic [7:0]         cell_q [dfe_pkg::FRAME_MAX];

  logic          inside_r, inside_nxt;
  logic [RW-1:0] rec_r, rec_nxt;
  logic [CW-1:0] stored_r, stored_nxt;
  logic [BW-1:0] bss_r, bss_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] emit_cnt_r, emit_cnt_nxt;

  logic          in_xfer, out_xfer;
  logic [7:0]    rx;
  logic [RW-1:0] rec_shift;
  logic          start_hit, end_hit;

  // Last len received bytes against pattern bytes, oldest first
  function automatic logic tail_match(logic [RW-1:0] rec, logic [31:0] pat,
                                      logic [2:0] len);
    logic ok;
    logic m;
    ok = 1'b1;
    for (int l = 1; l <= dfe_pkg::PAT_CAP; l++) begin
      m = 1'b1;
      for (int k = 0; k < l; k++) begin
        m &= (rec[8*(l-1-k) +: 8] == pat[8*k +: 8]);
      end
      if (len == 3'(l)) ok = m;
    end
    return ok;
  endfunction

  function automatic logic [BW-1:0] sat_inc(logic [BW-1:0] v);
    return (v < dfe_pkg::BSS_SAT) ? v + BW'(1) : v;
  endfunction

  dfe_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Row of byte cells, each shifting toward cell 0
  for (genvar i = 0; i < dfe_pkg::FRAME_MAX; i++) begin : g_cell
    logic [7:0] nbr;
    if (i == dfe_pkg::FRAME_MAX - 1) begin : g_end
      assign nbr = 8'h00;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    dfe_cell u_cell (
      .clk       (clk),
      .cell_idx  (IW'(i)),
      .ctl       (cell_ctl),
      .nbr_byte  (nbr),
      .cell_byte (cell_q[i])
    );
  end

  // Handshakes
  assign in_ch.ready       = (emit_cnt_r == '0);
  assign out_ch.valid      = (emit_cnt_r != '0);
  assign out_ch.frame_byte = cell_q[0];
  assign out_ch.frame_last = (emit_cnt_r == CW'(1));
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign rx       = in_ch.rx_byte;

  assign rec_shift = {rec_r[RW-9:0], rx};
  assign start_hit = tail_match(rec_shift, cfg.start_pat, cfg.sl);
  assign end_hit   = tail_match(rec_shift, cfg.end_pat, cfg.el);

  // Framing control
  always_comb begin
    logic          full;
    logic [7:0]    first;
    logic [CW-1:0] fill_after;
    logic [CW-1:0] base_stored;
    logic [BW-1:0] base_bss;
    logic [BW-1:0] bss_inc;
    logic          wr_ok;
    logic [CW-1:0] stored_after;
    logic [CW-1:0] sl_ext;

    inside_nxt   = inside_r;
    rec_nxt      = rec_r;
    stored_nxt   = stored_r;
    bss_nxt      = bss_r;
    fill_nxt     = fill_r;
    emit_cnt_nxt = out_xfer ? emit_cnt_r - CW'(1) : emit_cnt_r;

    cell_ctl          = '0;
    cell_ctl.shift    = out_xfer;
    cell_ctl.wr_byte  = rx;
    cell_ctl.hdr_pat  = cfg.start_pat;

    full         = (fill_r >= cfg.lim);
    first        = '0;
    fill_after   = '0;
    base_stored  = inside_r ? stored_r : '0;
    base_bss     = inside_r ? bss_r : '0;
    bss_inc      = '0;
    wr_ok        = 1'b0;
    stored_after = '0;
    sl_ext       = CW'(cfg.sl);

    if (cfg.restart) begin
      inside_nxt = 1'b0;
      rec_nxt    = '0;
      stored_nxt = '0;
      bss_nxt    = '0;
      fill_nxt   = '0;
    end else if (in_xfer && cfg.fixed) begin
      // Sliding window: shift once full, else append
      if (full) begin
        cell_ctl.shift  = 1'b1;
        cell_ctl.wr_ptr = IW'(cfg.lim - CW'(1));
        first           = (cfg.lim > CW'(1)) ? cell_q[1] : rx;
        fill_after      = cfg.lim;
      end else begin
        cell_ctl.wr_ptr = IW'(fill_r);
        first           = (fill_r == '0) ? rx : cell_q[0];
        fill_after      = fill_r + CW'(1);
      end
      cell_ctl.wr_en = 1'b1;
      if ((fill_after == cfg.lim) && (first == cfg.start_pat[7:0]) &&
          (rx == cfg.end_pat[7:0])) begin
        fill_nxt     = '0;
        emit_cnt_nxt = cfg.lim;
      end else begin
        fill_nxt = fill_after;
      end
    end else if (in_xfer) begin
      rec_nxt = rec_shift;
      if (!inside_r && (cfg.sl != 3'd0)) begin
        // Hunting for the start pattern
        bss_inc = sat_inc(bss_r);
        if ((bss_inc >= BW'(cfg.sl)) && start_hit) begin
          inside_nxt        = 1'b1;
          bss_nxt           = '0;
          stored_nxt        = (sl_ext < cfg.lim) ? sl_ext : cfg.lim;
          cell_ctl.hdr_load = 1'b1;
          cell_ctl.hdr_cnt  = 3'(stored_nxt);
        end else begin
          bss_nxt = bss_inc;
        end
      end else begin
        // Collecting; a headerless frame opens on this byte
        wr_ok           = (base_stored < cfg.lim);
        cell_ctl.wr_en  = wr_ok;
        cell_ctl.wr_ptr = IW'(base_stored);
        stored_after    = base_stored + CW'(wr_ok);
        bss_inc         = sat_inc(base_bss);
        if ((bss_inc >= BW'(cfg.el)) && end_hit) begin
          inside_nxt   = 1'b0;
          stored_nxt   = '0;
          bss_nxt      = '0;
          emit_cnt_nxt = stored_after;
        end else begin
          inside_nxt = 1'b1;
          stored_nxt = stored_after;
          bss_nxt    = bss_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r   <= 1'b0;
      rec_r      <= '0;
      stored_r   <= '0;
      bss_r      <= '0;
      fill_r     <= '0;
      emit_cnt_r <= '0;
    end else begin
      inside_r   <= inside_nxt;
      rec_r      <= rec_nxt;
      stored_r   <= stored_nxt;
      bss_r      <= bss_nxt;
      fill_r     <= fill_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

  // Checks
  `DFE_ASSERT_IMP(a_emit_range, out_ch.valid, emit_cnt_r <= CW'(dfe_pkg::FRAME_MAX), "emit count beyond frame store")
  `DFE_ASSERT_NXT(a_last_ends, out_xfer && out_ch.frame_last, !out_ch.valid, "frame continues after last byte")
  `DFE_ASSERT_NXT(a_burst_holds, out_xfer && !out_ch.frame_last, out_ch.valid, "frame burst broken before last byte")
  `DFE_ASSERT_IMP(a_stored_lim, !cfg.fixed, stored_r <= cfg.lim, "stored count beyond frame limit")
  `DFE_ASSERT_IMP(a_fill_lim, cfg.fixed, fill_r <= cfg.lim, "window fill beyond frame limit")

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Spare register slots past the last real register
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_BYTES   = 23;
  localparam int MAX_PRINTS    = 40;

  typedef logic [7:0] byte_list_t[$];
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic clk;
  logic rst_n;

  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [dfe_pkg::ADDR_W-1:0] paddr   = '0;
  logic [dfe_pkg::DATA_W-1:0] pwdata  = '0;
  logic [dfe_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  dfe_in_if  in_if ();
  dfe_out_if out_if ();

  delimited_frame_extractor_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Deframer shadow: register copy
  logic        cfg_fixed;
  logic [31:0] cfg_start_pat;
  logic [31:0] cfg_end_pat;
  logic [2:0]  cfg_start_len;
  logic [2:0]  cfg_end_len;
  logic [6:0]  cfg_limit;

  // Deframer shadow: framing state
  logic        in_frame;
  logic [31:0] recent;
  logic [7:0]  store [dfe_pkg::FRAME_MAX];
  int          store_cnt;
  int          since_start;
  int          win_fill;

  byte_list_t  pending_rx;
  frame_beat_t expected_beats[$];
  frame_beat_t want;

  int   mismatches  = 0;
  int   idle_cycles = 0;
  logic rx_took;
  int   rx_gap;
  bit   rx_calm = 1'b0;
  int   tx_hold;
  bit   tx_calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clamp_len(input logic [2:0] v, input int lo);
    int n;
    n = v;
    if (n < lo) n = lo;
    if (n > dfe_pkg::PAT_CAP) n = dfe_pkg::PAT_CAP;
    return n;
  endfunction

  function automatic int limit_len();
    int n;
    n = cfg_limit;
    if (n < 1) n = 1;
    if (n > dfe_pkg::FRAME_MAX) n = dfe_pkg::FRAME_MAX;
    return n;
  endfunction

  // last len bytes received equal pattern bytes, oldest first
  function automatic bit tail_match(input logic [31:0] pat, input int len);
    for (int k = 0; k < len; k++) begin
      if (recent[8*(len-1-k) +: 8] != pat[8*k +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic restart_framing();
    in_frame    = 1'b0;
    recent      = '0;
    store_cnt   = 0;
    since_start = 0;
    win_fill    = 0;
  endtask

  task automatic emit_frame(input int n);
    for (int i = 0; i < n; i++) expected_beats.push_back(frame_beat_t'{store[i], i == n - 1});
  endtask

  // Expected frames caused by one received byte
  task automatic deframe_byte(input logic [7:0] b);
    int lim;
    int sl;
    int el;
    lim = limit_len();
    if (cfg_fixed) begin
      if (win_fill >= lim) begin
        for (int i = 0; i < lim - 1; i++) store[i] = store[i+1];
        store[lim-1] = b;
        win_fill = lim;
      end else begin
        store[win_fill] = b;
        win_fill++;
      end
      if (win_fill == lim && store[0] == cfg_start_pat[7:0] &&
          store[lim-1] == cfg_end_pat[7:0]) begin
        win_fill = 0;
        emit_frame(lim);
      end
      return;
    end
    sl = clamp_len(cfg_start_len, 0);
    el = clamp_len(cfg_end_len, 1);
    recent = {recent[23:0], b};
    if (!in_frame) begin
      if (sl == 0) begin
        in_frame    = 1'b1;
        store_cnt   = 0;
        since_start = 0;
      end else begin
        if (since_start < 8) since_start++;
        if (since_start < sl || !tail_match(cfg_start_pat, sl)) return;
        in_frame    = 1'b1;
        since_start = 0;
        store_cnt   = 0;
        for (int k = 0; k < sl && store_cnt < lim; k++) begin
          store[store_cnt] = cfg_start_pat[8*k +: 8];
          store_cnt++;
        end
        return;
      end
    end
    if (store_cnt < lim) begin
      store[store_cnt] = b;
      store_cnt++;
    end
    if (since_start < 8) since_start++;
    if (since_start >= el && tail_match(cfg_end_pat, el)) begin
      in_frame    = 1'b0;
      since_start = 0;
      emit_frame(store_cnt);
      store_cnt   = 0;
    end
  endtask

  task automatic apply_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      dfe_pkg::REG_FIXED_MODE:    cfg_fixed     = val[0];
      dfe_pkg::REG_START_PATTERN: cfg_start_pat = val;
      dfe_pkg::REG_START_LENGTH:  cfg_start_len = val[2:0];
      dfe_pkg::REG_END_PATTERN:   cfg_end_pat   = val;
      dfe_pkg::REG_END_LENGTH:    cfg_end_len   = val[2:0];
      dfe_pkg::REG_FRAME_LIMIT:   cfg_limit     = val[6:0];
      default:                    return;
    endcase
    restart_framing();
  endtask

  // Setup then access; the write lands on the access edge
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Length and limit fields carry junk in the unused upper bits
  task automatic set_config(input logic fixed, input logic [31:0] spat, input logic [2:0] slen,
                            input logic [31:0] epat, input logic [2:0] elen,
                            input logic [6:0] lim);
    write_reg(dfe_pkg::REG_FIXED_MODE, {31'($urandom), fixed});
    write_reg(dfe_pkg::REG_START_PATTERN, spat);
    write_reg(dfe_pkg::REG_START_LENGTH, {29'($urandom), slen});
    write_reg(dfe_pkg::REG_END_PATTERN, epat);
    write_reg(dfe_pkg::REG_END_LENGTH, {29'($urandom), elen});
    write_reg(dfe_pkg::REG_FRAME_LIMIT, {25'($urandom), lim});
  endtask

  // Block is idle once all bytes are in and every frame byte is out;
  // sampled mid-cycle so the driver's edge updates have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_rx.size() != 0 || in_if.valid || expected_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_bytes(input byte_list_t bytes);
    foreach (bytes[i]) pending_rx.push_back(bytes[i]);
    wait_idle();
  endtask

  // Body bytes lean on pattern bytes to provoke partial matches
  function automatic logic [7:0] body_byte();
    int sel;
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 7);
    return (sel < 4) ? cfg_start_pat[8*sel +: 8] : cfg_end_pat[8*(sel-4) +: 8];
  endfunction

  // One well-formed frame with random content, sometimes noise first or a cut end
  task automatic add_sequence();
    int sl;
    int el;
    int lim;
    int body;
    int r;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) pending_rx.push_back(8'($urandom_range(0, 255)));
    end
    lim = limit_len();
    if (cfg_fixed) begin
      pending_rx.push_back(cfg_start_pat[7:0]);
      if (lim > 1) begin
        repeat (lim - 2) pending_rx.push_back(body_byte());
        pending_rx.push_back(cfg_end_pat[7:0]);
      end
    end else begin
      sl = clamp_len(cfg_start_len, 0);
      el = clamp_len(cfg_end_len, 1);
      for (int k = 0; k < sl; k++) pending_rx.push_back(cfg_start_pat[8*k +: 8]);
      r = $urandom_range(0, 19);
      if (r < 16) body = $urandom_range(0, 6);
      else if (r < 19) body = $urandom_range(7, 20);
      else body = $urandom_range(60, 70);
      repeat (body) pending_rx.push_back(body_byte());
      if ($urandom_range(0, 9) == 0) el--;
      for (int k = 0; k < el; k++) pending_rx.push_back(cfg_end_pat[8*k +: 8]);
    end
  endtask

  // Byte driver: one transfer per accepted byte, random gaps between
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.rx_byte <= '0;
      rx_gap = 0;
    end else begin
      rx_took = in_if.valid && in_if.ready;
      if (rx_took) begin
        deframe_byte(in_if.rx_byte);
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_gap = pick_gap(rx_calm);
      end
      if (rx_took || !in_if.valid) begin
        if (rx_gap > 0 || pending_rx.size() == 0) begin
          if (rx_gap > 0) rx_gap--;
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid   <= 1'b1;
          in_if.rx_byte <= pending_rx.pop_front();
        end
      end
    end
  end

  // Frame monitor with random receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      tx_hold = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("frame byte %02h with no frame pending",
                                    out_if.frame_byte));
        end else begin
          want = expected_beats.pop_front();
          if (out_if.frame_byte !== want.data)
            report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                      out_if.frame_byte, want.data));
          if (out_if.frame_last !== want.last)
            report_mismatch($sformatf("frame_last %0b, expected %0b",
                                      out_if.frame_last, want.last));
        end
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      end
      if (tx_hold > 0) begin
        tx_hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) tx_hold = pick_gap(tx_calm);
      end
    end
  end

  // Watchdog on cycles with no transfer and no register write
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable && pready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("delimited_frame_extractor_core regression: fail");
      $finish;
    end
  end

  initial begin
    logic        rf;
    logic [31:0] rsp;
    logic [31:0] rep;
    logic [2:0]  rsl;
    logic [2:0]  rel;
    logic [6:0]  rlim;
    int          r;

    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready  = 1'b0;
    rst_n         = 1'b0;
    cfg_fixed     = 1'b0;
    cfg_start_pat = '0;
    cfg_start_len = 3'd1;
    cfg_end_pat   = '0;
    cfg_end_len   = 3'd1;
    cfg_limit     = 7'd64;
    restart_framing();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Two-byte delimiters of all-ones and all-zeros; end may not reuse start bytes
    set_config(1'b0, 32'h0000_00FF, 3'd2, 32'h0000_FF00, 3'd2, 7'd64);
    run_bytes('{8'h55, 8'hFF, 8'h00, 8'h00, 8'hFF});

    // Headerless frames, including a single end byte on its own
    set_config(1'b0, 32'h0000_0000, 3'd0, 32'h0000_007E, 3'd1, 7'd64);
    run_bytes('{8'h7E});
    run_bytes('{8'h01, 8'h80, 8'h7E});

    // Oversized start length, zero end length, zero limit cuts to one byte
    set_config(1'b0, 32'h0403_0201, 3'd5, 32'h0000_00EE, 3'd0, 7'd0);
    run_bytes('{8'h01, 8'h02, 8'h03, 8'h04, 8'hAA, 8'hEE});

    // Fixed window: only the low pattern bytes count
    set_config(1'b1, 32'h1234_56FF, 3'd7, 32'hFFFF_FF00, 3'd4, 7'd3);
    run_bytes('{8'hFF, 8'hFF, 8'h12, 8'h00});

    // Spare register writes leave a frame in progress alone
    set_config(1'b0, 32'h0000_0011, 3'd1, 32'h0000_0022, 3'd1, 7'd64);
    run_bytes('{8'h11, 8'h33});
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    run_bytes('{8'h22});

    // A real register write mid-frame restarts the hunt
    run_bytes('{8'h11, 8'h44});
    write_reg(dfe_pkg::REG_END_PATTERN, 32'h0000_0022);
    run_bytes('{8'h22, 8'h11, 8'h22});

    // Random settings, the first few pinned to the extremes
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      rf  = ($urandom_range(0, 2) == 0);
      rsp = $urandom;
      rep = $urandom;
      if ($urandom_range(0, 3) == 0) rsp = {4{rsp[7:0]}};
      rsl = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      r = $urandom_range(0, 9);
      if (r == 0) rel = 3'd0;
      else if (r == 1) rel = 3'($urandom_range(5, 7));
      else rel = 3'($urandom_range(1, 4));
      r = $urandom_range(0, 19);
      if (r == 0) rlim = 7'd0;
      else if (r == 1) rlim = 7'($urandom_range(65, 127));
      else if (r < 4) rlim = 7'd64;
      else rlim = 7'($urandom_range(1, 16));
      if (rf && $urandom_range(0, 1) == 1) rep[7:0] = rsp[7:0];
      case (ph)
        0: begin
          rf   = 1'b0;
          rsl  = 3'd4;
          rel  = 3'd4;
          rlim = 7'd64;
        end
        1: begin
          rf   = 1'b1;
          rlim = 7'd64;
        end
        2: begin
          rf   = 1'b0;
          rsl  = 3'd0;
          rel  = 3'd1;
          rlim = 7'd1;
        end
        3: begin
          rf       = 1'b1;
          rlim     = 7'd1;
          rep[7:0] = rsp[7:0];
        end
        default: ;
      endcase
      set_config(rf, rsp, rsl, rep, rel, rlim);
      while (pending_rx.size() < PHASE_BYTES) add_sequence();
      wait_idle();
    end

    wait_idle();
    if (expected_beats.size() != 0)
      report_mismatch($sformatf("%0d frame bytes never delivered", expected_beats.size()));
    if (mismatches == 0)
      $display("delimited_frame_extractor_core regression: pass");
    else
      $display("delimited_frame_extractor_core regression: fail");
    $finish;
  end

endmodule
